### design/isc_pkg.sv
// Shared types and constants for the insertion sorter with counts.
// No dependencies; imported by the top level.
package isc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned STAT_W = 12;
    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};
    localparam int unsigned OUT_TDATA_W = 64;
    localparam int unsigned OUT_PAD_W = OUT_TDATA_W - (DATA_W + 2 * STAT_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT_FIRST,
        ST_EMIT_SEND
    } isc_state_t;

    // saturating counter step
    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] c);
        logic [STAT_W-1:0] r;
        begin
            r = (c == STAT_MAX) ? c : c + STAT_W'(1);
            return r;
        end
    endfunction

endpackage

### design/isc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module isc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/insertion_sorter_with_counts.sv
// Insertion sorter with comparison and move counts. Uses isc_pkg and isc_ram.
// Insertion: the first value of a set is written directly; otherwise one probe read,
// then k shift steps (one RAM read-modify-write per cycle) and a final placement write,
// k being the number of stored elements shifted up. Emission on a last transaction: a
// read set-up step, then one result per cycle while m_axis_tready is high. A full store drops the value.
// Reset (asynchronous, active low) empties the set and sets ascending order.
module insertion_sorter_with_counts
    import isc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,     // ascending_order
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,  // value
    input  logic                   s_axis_tlast,  // last
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sorted_value[31:0], comparison_count[43:32], move_count[55:44],
    // overflow[56], zero pad above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast   // last_out
);

    localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);

    isc_state_t         state_reg, state_next;
    logic               asc_cfg_reg;
    logic               asc_reg, asc_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    logic               last_reg, last_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STAT_W-1:0]  cmp_reg, cmp_next;
    logic [STAT_W-1:0]  mov_reg, mov_next;
    logic               drop_reg, drop_next;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0]  ram_wdata, ram_rdata;

    logic               in_fire, out_fire, full, must_move, emit_done;

    isc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_EMIT_SEND);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign full          = (count_reg == CNT_W'(MAX_ITEMS));
    assign emit_done     = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign must_move     = asc_reg ? ($signed(ram_rdata) > $signed(key_reg))
                                   : ($signed(ram_rdata) < $signed(key_reg));

    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, drop_reg, mov_reg, cmp_reg, ram_rdata};
    assign m_axis_tlast  = emit_done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (full || count_reg == '0)
                    begin
                        state_next = s_axis_tlast ? ST_EMIT_FIRST : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (must_move)
                begin
                    if (pos_reg == ADDR_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = last_reg ? ST_EMIT_FIRST : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                state_next = last_reg ? ST_EMIT_FIRST : ST_IDLE;
            end
            ST_EMIT_FIRST:
            begin
                state_next = ST_EMIT_SEND;
            end
            ST_EMIT_SEND:
            begin
                if (out_fire && emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        asc_next   = asc_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        cmp_next   = cmp_reg;
        mov_next   = mov_reg;
        drop_next  = drop_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = key_reg;
        ram_re     = 1'b0;
        ram_raddr  = pos_reg - ADDR_W'(2);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    asc_next  = asc_cfg_reg;
                    key_next  = s_axis_tdata;
                    last_next = s_axis_tlast;
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = s_axis_tdata;
                        count_next = CNT_W'(1);
                    end
                    else
                    begin
                        // probe the nearest neighbour
                        pos_next  = count_reg[ADDR_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = count_reg[ADDR_W-1:0] - ADDR_W'(1);
                        cmp_next  = sat_inc(cmp_reg);
                    end
                end
            end
            ST_SHIFT:
            begin
                ram_we   = 1'b1;
                ram_waddr = pos_reg;
                mov_next = sat_inc(mov_reg);
                if (must_move)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - ADDR_W'(1);
                    if (pos_reg != ADDR_W'(1))
                    begin
                        ram_re   = 1'b1;
                        cmp_next = sat_inc(cmp_reg);
                    end
                end
                else
                begin
                    ram_wdata  = key_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_PLACE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = key_reg;
                mov_next   = sat_inc(mov_reg);
                count_next = count_reg + CNT_W'(1);
            end
            ST_EMIT_FIRST:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_next  = '0;
            end
            ST_EMIT_SEND:
            begin
                if (out_fire)
                begin
                    if (emit_done)
                    begin
                        count_next = '0;
                        cmp_next   = '0;
                        mov_next   = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + ADDR_W'(1);
                        idx_next  = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            asc_cfg_reg <= 1'b1;
            count_reg   <= '0;
            cmp_reg     <= '0;
            mov_reg     <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                asc_cfg_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            cmp_reg   <= cmp_next;
            mov_reg   <= mov_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asc_reg  <= asc_next;
        key_reg  <= key_next;
        last_reg <= last_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
    end

endmodule
